// ===== hdl/sfr_pkg.sv =====
package sfr_pkg;

  localparam int LEN_W         = 4;
  localparam int BYTE_W        = 8;
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_ADDR_W    = 5;
  localparam int PATTERN_MAX_DEF     = 8;
  localparam int REPLACEMENT_MAX_DEF = 8;

  typedef enum logic [1:0] {
    REG_PATTERN_BYTES      = 2'd0,
    REG_PATTERN_LENGTH     = 2'd1,
    REG_REPLACEMENT_BYTES  = 2'd2,
    REG_REPLACEMENT_LENGTH = 2'd3
  } reg_idx_t;

endpackage

// ===== hdl/sfr_stream_if.sv =====
interface sfr_in_if;
  logic                       valid;
  logic                       ready;
  logic [sfr_pkg::BYTE_W-1:0] in_byte;
  logic                       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface sfr_out_if;
  logic                       valid;
  logic                       ready;
  logic [sfr_pkg::BYTE_W-1:0] out_byte;
  logic                       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// ===== hdl/stream_find_and_replace_unit.sv =====
// Streaming find-and-replace over a byte string.
// in_ch carries one byte per transaction, in_last marks the final byte of a
// string. out_ch carries the rewritten string, out_last on its final byte
// (a string that ends in a deleted match has no byte flagged).
// The APB port sets the search word, its length (1..8), the replacement word
// and its length (0..8, zero deletes); write it only while the stream is idle.
// Writing the search length empties the lookahead window.
// Each accepted byte is matched against the window combinationally and its
// results land in a burst buffer, which drains one byte per cycle into the
// output register while the receiver does not stall.
// Throughput is one byte per cycle while each byte yields at most one result
// and the receiver does not stall; a match or a last byte that yields more
// results holds in_ch.ready low until the burst buffer is down to its final byte.
// Reset empties the window, burst buffer and output register and restores
// the register defaults. A stalled receiver holds the output register; the
// burst buffer takes transactions only while empty, then in_ch.ready drops.
module stream_find_and_replace_unit #(
  parameter int PATTERN_MAX     = sfr_pkg::PATTERN_MAX_DEF,
  parameter int REPLACEMENT_MAX = sfr_pkg::REPLACEMENT_MAX_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  sfr_in_if.sink                         in_ch,
  sfr_out_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sfr_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [sfr_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [sfr_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);

  localparam int LW = sfr_pkg::LEN_W;
  localparam int BW = sfr_pkg::BYTE_W;
  localparam int BURST = (PATTERN_MAX > REPLACEMENT_MAX) ? PATTERN_MAX : REPLACEMENT_MAX;

  logic [sfr_pkg::CFG_DATA_W-1:0] pattern_r;
  logic [LW-1:0]                  pattern_len_r;
  logic [sfr_pkg::CFG_DATA_W-1:0] repl_r;
  logic [LW-1:0]                  repl_len_r;

  logic [BW-1:0] win_r   [PATTERN_MAX];
  logic [BW-1:0] win_nxt [PATTERN_MAX];
  logic [LW-1:0] fill_r, fill_nxt;

  logic [BW-1:0] burst_r   [BURST];
  logic [BW-1:0] burst_nxt [BURST];
  logic [LW-1:0] rem_r;
  logic          burst_last_r;

  logic          out_valid_r;
  logic [BW-1:0] out_byte_r;
  logic          out_last_r;

  logic [LW-1:0] plen, rlen, fill_c, nfill, cnt;
  logic [BW-1:0] w [BURST];
  logic          full, hit;
  logic          cfg_wr, in_acc, o_load, pop;
  sfr_pkg::reg_idx_t reg_idx;

  assign reg_idx = sfr_pkg::reg_idx_t'(paddr[4:3]);
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_idx)
      sfr_pkg::REG_PATTERN_BYTES:      prdata = pattern_r;
      sfr_pkg::REG_PATTERN_LENGTH:     prdata = {{(sfr_pkg::CFG_DATA_W-LW){1'b0}}, pattern_len_r};
      sfr_pkg::REG_REPLACEMENT_BYTES:  prdata = repl_r;
      sfr_pkg::REG_REPLACEMENT_LENGTH: prdata = {{(sfr_pkg::CFG_DATA_W-LW){1'b0}}, repl_len_r};
      default:                         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r     <= '0;
      pattern_len_r <= LW'(1);
      repl_r        <= '0;
      repl_len_r    <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        sfr_pkg::REG_PATTERN_BYTES:      pattern_r     <= pwdata;
        sfr_pkg::REG_PATTERN_LENGTH:     pattern_len_r <= pwdata[LW-1:0];
        sfr_pkg::REG_REPLACEMENT_BYTES:  repl_r        <= pwdata;
        sfr_pkg::REG_REPLACEMENT_LENGTH: repl_len_r    <= pwdata[LW-1:0];
        default: ;
      endcase
    end
  end

  // effective lengths
  always_comb begin
    if (pattern_len_r == '0) begin
      plen = LW'(1);
    end else if (pattern_len_r > LW'(PATTERN_MAX)) begin
      plen = LW'(PATTERN_MAX);
    end else begin
      plen = pattern_len_r;
    end
    rlen = (repl_len_r > LW'(REPLACEMENT_MAX)) ? LW'(REPLACEMENT_MAX) : repl_len_r;
  end

  // insert, compare, build result list
  always_comb begin
    fill_c = (fill_r >= plen) ? plen - LW'(1) : fill_r;
    nfill  = fill_c + LW'(1);
    full   = (nfill == plen);
    for (int k = 0; k < BURST; k++) begin
      if (k < PATTERN_MAX) begin
        w[k] = (LW'(k) == fill_c) ? in_ch.in_byte : win_r[k];
      end else begin
        w[k] = '0;
      end
    end
    hit = full;
    for (int k = 0; k < PATTERN_MAX; k++) begin
      if ((LW'(k) < plen) && (w[k] != pattern_r[BW*k +: BW])) hit = 1'b0;
    end
    for (int k = 0; k < BURST; k++) begin
      burst_nxt[k] = hit ? repl_r[BW*k +: BW] : w[k];
    end
    if (hit) begin
      cnt = rlen;
    end else if (in_ch.in_last) begin
      cnt = nfill;
    end else begin
      cnt = full ? LW'(1) : '0;
    end
    for (int k = 0; k < PATTERN_MAX; k++) begin
      if (full && !hit && (k + 1 < PATTERN_MAX)) begin
        win_nxt[k] = w[k+1];
      end else begin
        win_nxt[k] = w[k];
      end
    end
    if (hit || in_ch.in_last) begin
      fill_nxt = '0;
    end else if (full) begin
      fill_nxt = plen - LW'(1);
    end else begin
      fill_nxt = nfill;
    end
  end

  assign o_load      = !out_valid_r || out_ch.ready;
  assign pop         = (rem_r != '0) && o_load;
  assign in_ch.ready = (rem_r == '0) || ((rem_r == LW'(1)) && o_load);
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      win_r <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cfg_wr && (reg_idx == sfr_pkg::REG_PATTERN_LENGTH)) begin
      fill_r <= '0;
    end else if (in_acc) begin
      fill_r <= fill_nxt;
    end
  end

  // burst buffer: load on accept, shift on drain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r        <= '0;
      burst_last_r <= 1'b0;
    end else if (in_acc) begin
      rem_r        <= cnt;
      burst_last_r <= in_ch.in_last;
    end else if (pop) begin
      rem_r <= rem_r - LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      burst_r <= burst_nxt;
    end else if (pop) begin
      for (int k = 0; k + 1 < BURST; k++) begin
        burst_r[k] <= burst_r[k+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (o_load) begin
      out_valid_r <= (rem_r != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      out_byte_r <= burst_r[0];
      out_last_r <= burst_last_r && (rem_r == LW'(1));
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.out_last = out_last_r;

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r < plen)
    else $error("window fill reached search length");

  a_rem_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= LW'(BURST))
    else $error("burst count exceeds buffer depth");

  a_out_from_burst: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(rem_r != '0))
    else $error("output valid without pending burst byte");

  a_accept_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.in_last) |=> (fill_r == '0))
    else $error("window not flushed after last byte");

endmodule

// ===== sim/tb.sv =====
module tb;

  typedef struct packed {
    logic [sfr_pkg::BYTE_W-1:0] value;
    logic                       last;
  } out_char_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_BYTE, ROW_TYPED} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    sfr_pkg::reg_idx_t idx;
    logic [63:0]       value;
    logic [7:0]        data;
    logic              last;
    int                n_typed;
    out_char_t         typed;
  } script_row_t;

  logic                           clk;
  logic                           rst_n;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [sfr_pkg::CFG_ADDR_W-1:0] paddr;
  logic [sfr_pkg::CFG_DATA_W-1:0] pwdata;
  logic [sfr_pkg::CFG_DATA_W-1:0] prdata;
  logic                           pready;

  sfr_in_if  in_ch ();
  sfr_out_if out_ch ();

  stream_find_and_replace_unit dut (
    .clk, .rst_n, .in_ch, .out_ch,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  logic [63:0] search_word;
  logic [63:0] subst_word;
  logic [3:0]  search_len;
  logic [3:0]  subst_len;
  logic [7:0]  window [8];
  int          window_fill;
  out_char_t   expected_chars[$];
  out_char_t   step_chars[$];
  script_row_t script[$];
  int          errors = 0;
  bit          src_steady;
  bit          sink_steady;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic report(input string what);
    $display("tb: mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  function automatic void rewrite_byte(input logic [7:0] data, input logic last);
    int        plen;
    int        rlen;
    bit        hit;
    out_char_t tail;
    plen = (search_len == 0) ? 1 : (search_len > 8) ? 8 : int'(search_len);
    rlen = (subst_len > 8) ? 8 : int'(subst_len);
    step_chars.delete();
    if (window_fill >= plen) window_fill = plen - 1;
    window[window_fill] = data;
    window_fill++;
    if (window_fill == plen) begin
      hit = 1'b1;
      for (int i = 0; i < plen; i++)
        if (window[i] != search_word[8*i +: 8]) hit = 1'b0;
      if (hit) begin
        for (int i = 0; i < rlen; i++) step_chars.push_back({subst_word[8*i +: 8], 1'b0});
        window_fill = 0;
      end else begin
        step_chars.push_back({window[0], 1'b0});
        for (int i = 0; i < 7; i++) window[i] = window[i+1];
        window_fill--;
      end
    end
    if (last) begin
      for (int i = 0; i < window_fill; i++) step_chars.push_back({window[i], 1'b0});
      window_fill = 0;
      if (step_chars.size() > 0) begin
        tail = step_chars.pop_back();
        tail.last = 1'b1;
        step_chars.push_back(tail);
      end
    end
  endfunction

  task automatic write_reg(input sfr_pkg::reg_idx_t idx, input logic [63:0] value);
    in_ch.valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      sfr_pkg::REG_PATTERN_BYTES: search_word = value;
      sfr_pkg::REG_PATTERN_LENGTH: begin
        search_len  = value[3:0];
        window_fill = 0;
      end
      sfr_pkg::REG_REPLACEMENT_BYTES: subst_word = value;
      sfr_pkg::REG_REPLACEMENT_LENGTH: subst_len = value[3:0];
    endcase
  endtask

  task automatic send_byte(input logic [7:0] data, input logic last, input bit use_typed,
                           input int n_typed, input out_char_t typed);
    int gap;
    gap = src_steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= data;
    in_ch.in_last <= last;
    do @(posedge clk); while (!in_ch.ready);
    rewrite_byte(data, last);
    if (use_typed) begin
      if (n_typed == 1) expected_chars.push_back(typed);
    end else begin
      foreach (step_chars[i]) expected_chars.push_back(step_chars[i]);
    end
  endtask

  function automatic void add_cfg(input sfr_pkg::reg_idx_t idx, input logic [63:0] value);
    script_row_t r;
    r.kind  = ROW_CFG;
    r.idx   = idx;
    r.value = value;
    script.push_back(r);
  endfunction

  function automatic void add_byte(input logic [7:0] data, input logic last);
    script_row_t r;
    r.kind = ROW_BYTE;
    r.data = data;
    r.last = last;
    script.push_back(r);
  endfunction

  function automatic void add_typed(input logic [7:0] data, input logic last, input int n,
                                    input logic [7:0] want, input logic want_last);
    script_row_t r;
    r.kind    = ROW_TYPED;
    r.data    = data;
    r.last    = last;
    r.n_typed = n;
    r.typed   = {want, want_last};
    script.push_back(r);
  endfunction

  initial begin
    int          random_sent;
    int          phase_target;
    int          phase_sent;
    int          pick;
    int          plen;
    int          cut;
    int          str_len;
    logic [3:0]  len_code;
    logic [63:0] word;
    logic [7:0]  line[$];

    rst_n          <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.in_byte  <= '0;
    in_ch.in_last  <= 1'b0;
    search_word = '0;
    search_len  = 4'd1;
    subst_word  = '0;
    subst_len   = 4'd0;
    window_fill = 0;
    src_steady  = 1'b0;

    // defaults: delete every zero byte
    add_typed(8'h00, 1'b0, 0, 8'h00, 1'b0);
    add_typed(8'hFF, 1'b1, 1, 8'hFF, 1'b1);
    add_typed(8'h00, 1'b1, 0, 8'h00, 1'b0);
    add_typed(8'h7F, 1'b0, 1, 8'h7F, 1'b0);
    add_typed(8'h80, 1'b1, 1, 8'h80, 1'b1);
    add_cfg(sfr_pkg::REG_REPLACEMENT_BYTES, 64'h0000_0000_0000_00A5);
    add_cfg(sfr_pkg::REG_REPLACEMENT_LENGTH, 64'hFFFF_FFFF_FFFF_FFF1);
    add_typed(8'h00, 1'b1, 1, 8'hA5, 1'b1);
    // widest search and replacement words
    add_cfg(sfr_pkg::REG_PATTERN_BYTES, 64'hFFFF_FFFF_FFFF_FFFF);
    add_cfg(sfr_pkg::REG_PATTERN_LENGTH, 64'd8);
    add_cfg(sfr_pkg::REG_REPLACEMENT_BYTES, 64'h8877_6655_4433_2211);
    add_cfg(sfr_pkg::REG_REPLACEMENT_LENGTH, 64'd8);
    for (int i = 0; i < 8; i++) add_byte(8'hFF, i == 7);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h12, 1'b1);
    // zero search length acts as one, oversized replacement length as eight
    add_cfg(sfr_pkg::REG_PATTERN_LENGTH, 64'd0);
    add_cfg(sfr_pkg::REG_PATTERN_BYTES, 64'h41);
    add_cfg(sfr_pkg::REG_REPLACEMENT_LENGTH, 64'd15);
    add_byte(8'h41, 1'b0);
    add_byte(8'h42, 1'b1);
    // search length write drops pending bytes
    add_cfg(sfr_pkg::REG_PATTERN_BYTES, 64'h63_6261);
    add_cfg(sfr_pkg::REG_PATTERN_LENGTH, 64'd3);
    add_cfg(sfr_pkg::REG_REPLACEMENT_LENGTH, 64'd0);
    add_byte(8'h61, 1'b0);
    add_byte(8'h62, 1'b0);
    add_cfg(sfr_pkg::REG_PATTERN_LENGTH, 64'd3);
    add_byte(8'h63, 1'b1);
    // oversized search length acts as eight
    add_cfg(sfr_pkg::REG_PATTERN_LENGTH, 64'd15);
    add_byte(8'h78, 1'b0);
    add_byte(8'h79, 1'b1);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[k]) begin
      case (script[k].kind)
        ROW_CFG:   write_reg(script[k].idx, script[k].value);
        ROW_BYTE:  send_byte(script[k].data, script[k].last, 1'b0, 0, '0);
        ROW_TYPED: send_byte(script[k].data, script[k].last, 1'b1, script[k].n_typed,
                             script[k].typed);
      endcase
    end

    random_sent = 0;
    while (random_sent < 430) begin
      src_steady = ($urandom_range(0, 2) == 0);
      word = {$urandom, $urandom};
      if ($urandom_range(0, 1) == 1)
        for (int i = 0; i < 8; i++) word[8*i +: 8] = 8'h61 + 8'($urandom_range(0, 2));
      write_reg(sfr_pkg::REG_PATTERN_BYTES, word);
      pick = $urandom_range(0, 9);
      len_code = (pick == 0) ? 4'd0 : (pick == 1) ? 4'($urandom_range(9, 15))
                                                  : 4'($urandom_range(1, 8));
      write_reg(sfr_pkg::REG_PATTERN_LENGTH,
                ({$urandom, $urandom} & ~64'hF) | 64'(len_code));
      plen = (len_code == 0) ? 1 : (len_code > 8) ? 8 : int'(len_code);
      write_reg(sfr_pkg::REG_REPLACEMENT_BYTES, {$urandom, $urandom});
      pick = $urandom_range(0, 9);
      len_code = (pick == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
      write_reg(sfr_pkg::REG_REPLACEMENT_LENGTH,
                ({$urandom, $urandom} & ~64'hF) | 64'(len_code));

      phase_target = $urandom_range(20, 60);
      phase_sent   = 0;
      while (phase_sent < phase_target) begin
        str_len = $urandom_range(1, 16);
        line.delete();
        while (line.size() < str_len) begin
          pick = $urandom_range(0, 9);
          if (pick < 5) begin
            for (int i = 0; i < plen; i++) line.push_back(search_word[8*i +: 8]);
          end else if (pick == 5) begin
            cut = $urandom_range(1, plen);
            for (int i = 0; i < cut; i++) line.push_back(search_word[8*i +: 8]);
          end else if (pick < 8) begin
            line.push_back(search_word[8*$urandom_range(0, plen - 1) +: 8]);
          end else begin
            line.push_back(8'($urandom_range(0, 255)));
          end
        end
        foreach (line[i]) send_byte(line[i], i == line.size() - 1, 1'b0, 0, '0);
        phase_sent  += line.size();
        random_sent += line.size();
      end
    end

    in_ch.valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    int        gap;
    out_char_t want;
    out_ch.ready <= 1'b0;
    sink_steady = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if ($urandom_range(0, 31) == 0) sink_steady = !sink_steady;
      gap = sink_steady ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if (expected_chars.size() == 0) begin
        report($sformatf("unexpected transaction byte %h last %b",
                         out_ch.out_byte, out_ch.out_last));
      end else begin
        want = expected_chars.pop_front();
        if (out_ch.out_byte !== want.value)
          report($sformatf("out_byte %h, want %h", out_ch.out_byte, want.value));
        if (out_ch.out_last !== want.last)
          report($sformatf("out_last %b, want %b (byte %h)", out_ch.out_last, want.last,
                           want.value));
      end
    end
  end

endmodule
